FILE: hw/rtl/rcsp_pkg.sv
// Shared types and constants for the RGB color spec parser.
// Holds the character classes, status codes and sizing constants.
// Used by every module under hw/rtl.
package rcsp_pkg;

    localparam int OUT_DIGITS = 2;
    localparam int ACC_BITS   = 32;

    localparam int PREFIX_LEN = 4;
    localparam int POS_W      = $clog2(PREFIX_LEN);
    localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h72, 8'h67, 8'h62, 8'h3A};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] DIG_MAX = 4'd15;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
    localparam logic [2:0] ST_NO_SLASH1  = 3'd2;
    localparam logic [2:0] ST_NO_SLASH2  = 3'd3;
    localparam logic [2:0] ST_TRAILING   = 3'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic                  is_nul;
        logic                  is_slash;
        logic                  is_hex;
        logic [3:0]            hex_val;
        logic [PREFIX_LEN-1:0] pmatch;
    } t_char_class;

endpackage

FILE: hw/rtl/rcsp_front.sv
// Input side of the parser: classifies each character and pushes it to the queue.
// Depends on rcsp_pkg.
module rcsp_front (
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_ch,
    input  logic                 i_q_full,
    output logic                 o_push,
    output rcsp_pkg::t_char_class o_cls
);
    import rcsp_pkg::*;

    always_comb begin
        o_cls.is_nul   = (i_ch == CH_NUL);
        o_cls.is_slash = (i_ch == CH_SLASH);
        o_cls.is_hex   = 1'b0;
        o_cls.hex_val  = 4'd0;
        if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            o_cls.is_hex  = 1'b1;
            o_cls.hex_val = i_ch[3:0];
        end else if (i_ch >= 8'h61 && i_ch <= 8'h66) begin
            o_cls.is_hex  = 1'b1;
            o_cls.hex_val = 4'(i_ch - 8'h57);
        end else if (i_ch >= 8'h41 && i_ch <= 8'h46) begin
            o_cls.is_hex  = 1'b1;
            o_cls.hex_val = 4'(i_ch - 8'h37);
        end
        for (int k = 0; k < PREFIX_LEN; k++) begin
            o_cls.pmatch[k] = (i_ch == PREFIX_TEXT[k]);
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

FILE: hw/rtl/rcsp_queue.sv
// Short FIFO of classified characters between front and back.
// Depends on rcsp_pkg.
module rcsp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rcsp_pkg::t_char_class i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output rcsp_pkg::t_char_class o_data,
    output logic                  o_full
);
    import rcsp_pkg::*;

    t_char_class        r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = Q_PTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = Q_PTR_W'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = Q_CNT_W'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = Q_CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

endmodule

FILE: hw/rtl/rcsp_back.sv
// Back end of the parser: phase tracking, field accumulation, scaling and result register.
// Depends on rcsp_pkg; fed by rcsp_queue.
module rcsp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  rcsp_pkg::t_char_class i_q,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);
    import rcsp_pkg::*;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_WAIT
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [2:0]          r_first_error, n_first_error;
    logic [ACC_BITS-1:0] r_val [3];
    logic [ACC_BITS-1:0] n_val [3];
    logic [3:0]          r_dig [3];
    logic [3:0]          n_dig [3];
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_status, n_status;
    logic [7:0]          r_red, n_red;
    logic [7:0]          r_green, n_green;
    logic [7:0]          r_blue, n_blue;

    logic       out_free;
    logic       emit;
    logic [2:0] emit_status;
    logic [1:0] fi;
    logic [3:0] gmax;

    function automatic logic [7:0] f_scale(input logic [ACC_BITS-1:0] v, input logic [3:0] g);
        logic [ACC_BITS-1:0] s;
        logic [5:0]          amt;
        if (g < 4'(OUT_DIGITS)) begin
            amt = 6'(4 * (OUT_DIGITS - int'(g)));
            s   = v << amt;
        end else begin
            amt = 6'(4 * (int'(g) - OUT_DIGITS));
            s   = v >> amt;
        end
        return s[7:0];
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_q_valid && (!i_q.is_nul || out_free);

    always_comb begin
        case (r_phase)
            PH_GREEN: fi = 2'd1;
            PH_BLUE:  fi = 2'd2;
            default:  fi = 2'd0;
        endcase
        gmax = r_dig[0];
        if (r_dig[1] > gmax) gmax = r_dig[1];
        if (r_dig[2] > gmax) gmax = r_dig[2];
    end

    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_first_error = r_first_error;
        n_val         = r_val;
        n_dig         = r_dig;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_red         = r_red;
        n_green       = r_green;
        n_blue        = r_blue;
        emit          = 1'b0;
        emit_status   = ST_OK;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            case (r_phase)
                PH_PREFIX: begin
                    if (i_q.pmatch[r_pos]) begin
                        n_pos = POS_W'(r_pos + 1'b1);
                        if (r_pos == POS_W'(PREFIX_LEN - 1)) begin
                            n_phase = PH_RED;
                        end
                    end else if (i_q.is_nul) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_PREFIX;
                    end else begin
                        n_first_error = ST_BAD_PREFIX;
                        n_phase       = PH_WAIT;
                    end
                end
                PH_RED, PH_GREEN, PH_BLUE: begin
                    if (i_q.is_hex) begin
                        n_val[fi] = {r_val[fi][ACC_BITS-5:0], i_q.hex_val};
                        if (r_dig[fi] != DIG_MAX) begin
                            n_dig[fi] = 4'(r_dig[fi] + 1'b1);
                        end
                    end else if (r_phase == PH_BLUE) begin
                        if (i_q.is_nul) begin
                            emit        = 1'b1;
                            emit_status = ST_OK;
                        end else begin
                            n_first_error = ST_TRAILING;
                            n_phase       = PH_WAIT;
                        end
                    end else if (i_q.is_slash) begin
                        n_phase = (r_phase == PH_RED) ? PH_GREEN : PH_BLUE;
                    end else if (i_q.is_nul) begin
                        emit        = 1'b1;
                        emit_status = (r_phase == PH_RED) ? ST_NO_SLASH1 : ST_NO_SLASH2;
                    end else begin
                        n_first_error = (r_phase == PH_RED) ? ST_NO_SLASH1 : ST_NO_SLASH2;
                        n_phase       = PH_WAIT;
                    end
                end
                default: begin
                    if (i_q.is_nul) begin
                        emit        = 1'b1;
                        emit_status = (r_first_error != ST_OK) ? r_first_error : ST_BAD_PREFIX;
                    end
                end
            endcase
        end

        if (emit) begin
            n_out_valid   = 1'b1;
            n_status      = emit_status;
            n_red         = 8'd0;
            n_green       = 8'd0;
            n_blue        = 8'd0;
            if (emit_status == ST_OK) begin
                n_red   = f_scale(r_val[0], gmax);
                n_green = f_scale(r_val[1], gmax);
                n_blue  = f_scale(r_val[2], gmax);
            end
            n_phase       = PH_PREFIX;
            n_pos         = '0;
            n_first_error = ST_OK;
            for (int k = 0; k < 3; k++) begin
                n_val[k] = '0;
                n_dig[k] = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PREFIX;
            r_pos         <= '0;
            r_first_error <= ST_OK;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_val[k] <= '0;
                r_dig[k] <= 4'd0;
            end
        end else begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_first_error <= n_first_error;
            r_out_valid   <= n_out_valid;
            r_val         <= n_val;
            r_dig         <= n_dig;
        end
        r_status <= n_status;
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

`ifndef NO_ASSERTIONS
    a_wait_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_first_error != ST_OK))
        else $error("wait phase without a kept error");

    a_error_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_WAIT) |-> (r_first_error == ST_OK))
        else $error("error kept outside wait phase");

    a_error_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_red == 8'd0 && r_green == 8'd0 && r_blue == 8'd0))
        else $error("nonzero color with error status");

    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q.is_nul) |=> (r_phase == PH_PREFIX && r_pos == '0 && r_out_valid))
        else $error("string end did not restart parse and post result");
`endif

endmodule

FILE: hw/rtl/rgb_colour_spec_parser_core.sv
// RGB color spec parser, top level: takes one character per transaction and,
// at each NUL, returns a status and three 8-bit components. Accepts one character
// per cycle unless the queue is full (o_stall); a four-entry queue decouples
// classification from parsing and a result register decouples the back end from
// the output stall. The result is registered when the back end pops the NUL.
module rgb_colour_spec_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);
    import rcsp_pkg::*;

    t_char_class front_cls;
    t_char_class q_cls;
    logic        push;
    logic        pop;
    logic        q_valid;
    logic        q_full;

    rcsp_front u_front (
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_ch     (i_ch),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cls    (front_cls)
    );

    rcsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cls),
        .o_full  (q_full)
    );

    rcsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q       (q_cls),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

endmodule

FILE: dv/rgb_colour_spec_parser_core_checker.sv
// Checker for the RGB color spec parser: watches both channels, predicts each
// result from the accepted characters and compares it with what comes out.
// Depends on rcsp_pkg for status codes, prefix text and sizing constants.
module rgb_colour_spec_parser_core_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_ch,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_status,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rcsp_pkg::*;

    typedef enum logic [2:0] {PH_PREFIX, PH_RED, PH_GREEN, PH_BLUE, PH_WAIT} t_phase;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    t_phase              phase;
    logic [2:0]          prefix_pos;
    logic [2:0]          kept_error;
    logic [ACC_BITS-1:0] field_acc [3];
    logic [3:0]          field_cnt [3];

    t_colour colour_q [$];
    t_colour got_colour;
    t_colour want_colour;
    t_colour new_colour;
    bit      spec_done;
    int      fail_count = 0;

    task automatic clear_parse();
        phase      = PH_PREFIX;
        prefix_pos = '0;
        kept_error = ST_OK;
        for (int k = 0; k < 3; k++) begin
            field_acc[k] = '0;
            field_cnt[k] = '0;
        end
    endtask

    function automatic logic [7:0] scale_field(logic [ACC_BITS-1:0] v, int widest);
        int d;
        d = widest;
        while (d < OUT_DIGITS) begin
            v = v << 4;
            d++;
        end
        while (d > OUT_DIGITS) begin
            v = v >> 4;
            d--;
        end
        return v[7:0];
    endfunction

    task automatic close_spec(input logic [2:0] st, output t_colour r);
        int widest;
        r        = '0;
        r.status = st;
        if (st == ST_OK) begin
            widest = field_cnt[0];
            if (field_cnt[1] > widest) widest = field_cnt[1];
            if (field_cnt[2] > widest) widest = field_cnt[2];
            r.red   = scale_field(field_acc[0], widest);
            r.green = scale_field(field_acc[1], widest);
            r.blue  = scale_field(field_acc[2], widest);
        end
        clear_parse();
    endtask

    task automatic parse_char(input logic [7:0] c, output bit done, output t_colour r);
        bit         is_hex;
        logic [3:0] nib;
        int         f;
        logic [2:0] nul_st;
        logic [2:0] junk_st;
        done   = 0;
        r      = '0;
        is_hex = 1;
        nib    = '0;
        if (c >= "0" && c <= "9") nib = 4'(c - "0");
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
        else is_hex = 0;
        case (phase)
            PH_PREFIX: begin
                if (c == PREFIX_TEXT[prefix_pos[POS_W-1:0]]) begin
                    prefix_pos++;
                    if (prefix_pos == PREFIX_LEN) phase = PH_RED;
                end else if (c == CH_NUL) begin
                    close_spec(ST_BAD_PREFIX, r);
                    done = 1;
                end else begin
                    kept_error = ST_BAD_PREFIX;
                    phase      = PH_WAIT;
                end
            end
            PH_RED, PH_GREEN, PH_BLUE: begin
                f       = int'(phase) - int'(PH_RED);
                nul_st  = (phase == PH_RED) ? ST_NO_SLASH1 :
                          (phase == PH_GREEN) ? ST_NO_SLASH2 : ST_OK;
                junk_st = (phase == PH_RED) ? ST_NO_SLASH1 :
                          (phase == PH_GREEN) ? ST_NO_SLASH2 : ST_TRAILING;
                if (is_hex) begin
                    field_acc[f] = (field_acc[f] << 4) | ACC_BITS'(nib);
                    if (field_cnt[f] != DIG_MAX) field_cnt[f]++;
                end else if (phase != PH_BLUE && c == CH_SLASH) begin
                    phase = t_phase'(phase + 1);
                end else if (c == CH_NUL) begin
                    close_spec(nul_st, r);
                    done = 1;
                end else begin
                    kept_error = junk_st;
                    phase      = PH_WAIT;
                end
            end
            default: begin
                if (c == CH_NUL) begin
                    close_spec((kept_error != ST_OK) ? kept_error : ST_BAD_PREFIX, r);
                    done = 1;
                end
            end
        endcase
    endtask

    task automatic note_failure(input string what, input t_colour want, input t_colour got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("checker: %s exp status=%0d rgb=%02h/%02h/%02h",
                     what, want.status, want.red, want.green, want.blue);
            $display("checker:   got status=%0d rgb=%02h/%02h/%02h",
                     got.status, got.red, got.green, got.blue);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            colour_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got_colour.status = i_status;
                got_colour.red    = i_red;
                got_colour.green  = i_green;
                got_colour.blue   = i_blue;
                if (colour_q.size() == 0) begin
                    note_failure("unexpected result", '0, got_colour);
                end else begin
                    want_colour = colour_q.pop_front();
                    if (got_colour !== want_colour)
                        note_failure("result mismatch", want_colour, got_colour);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_in_ch, spec_done, new_colour);
                if (spec_done) colour_q.push_back(new_colour);
            end
        end
        o_pending    <= colour_q.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: dv/rgb_colour_spec_parser_core_test.sv
// Top of the RGB color spec parser testbench: clock, reset, character stimulus
// in idling phases and a long output hold-off, and the final verdict.
// Depends on rcsp_pkg, the core and rgb_colour_spec_parser_core_checker.
module rgb_colour_spec_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rcsp_pkg::*;

    localparam int PHASE_CHARS = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_ch;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_status;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    int         fail_count;
    int         pending;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         cycles = 0;
    logic       hold_go;
    logic       hold_rx;
    logic [7:0] spec [$];

    rgb_colour_spec_parser_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_ch     (i_ch),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

    rgb_colour_spec_parser_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_ch      (i_ch),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_status     (o_status),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            i_stall <= hold_rx || ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        hold_rx = 0;
        do @(posedge i_clk); while (!hold_go);
        hold_rx <= 1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 0;
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_ch    <= c;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_spec();
        foreach (spec[i]) send_char(spec[i]);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) spec.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    task automatic build_random_spec();
        int n;
        int mode;
        int at;
        spec.delete();
        push_text("rgb:");
        for (int f = 0; f < 3; f++) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(18, 9) : $urandom_range(4);
            repeat (n) spec.push_back(rand_hex_digit());
            if (f < 2) spec.push_back(CH_SLASH);
        end
        mode = $urandom_range(99);
        at   = $urandom_range(spec.size() - 1);
        if (mode < 70) begin
        end else if (mode < 78) begin
            spec[at] = 8'($urandom_range(255));
        end else if (mode < 84) begin
            while (spec.size() > at) spec.pop_back();
        end else if (mode < 90) begin
            spec.push_back(8'($urandom_range(255, 1)));
        end else if (mode < 95) begin
            spec.delete(at);
        end else begin
            spec.delete();
            n = $urandom_range(6);
            repeat (n) spec.push_back(8'($urandom_range(255)));
        end
        spec.push_back(CH_NUL);
    endtask

    initial begin
        int sent;
        i_rst_n        = 0;
        i_valid        = 0;
        i_ch           = CH_NUL;
        hold_go        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        spec.delete();
        spec.push_back(CH_NUL);
        send_spec();
        spec.delete();
        push_text("rgb:");
        spec.push_back(CH_NUL);
        send_spec();
        spec.delete();
        spec.push_back(8'hFF);
        spec.push_back(CH_NUL);
        send_spec();
        spec.delete();
        push_text("rgb:Ff/0/");
        spec.push_back(CH_NUL);
        send_spec();
        spec.delete();
        push_text("rgb:/Ab/c!");
        spec.push_back(CH_NUL);
        send_spec();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_go       <= 1;
                end
                1: begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            sent = 0;
            while (sent < PHASE_CHARS) begin
                build_random_spec();
                sent += spec.size();
                send_spec();
            end
        end
        i_valid <= 0;

        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
